>>> rtl/msd_pkg.sv
// ----------------------------------------------------------------------------
// msd_pkg
// Shared types, character codes and the code-to-character table of the
// Morse stream decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package msd_pkg;

    localparam int SYMBOL_W     = 8;
    localparam int CHAR_W       = 7;
    localparam int LOOKUP_LEN_W = 4;
    localparam int LOOKUP_PAT_W = 16;

    localparam logic [SYMBOL_W-1:0] ASCII_SPACE = 8'h20;
    localparam logic [SYMBOL_W-1:0] ASCII_DOT   = 8'h2E;
    localparam logic [SYMBOL_W-1:0] ASCII_DASH  = 8'h2D;
    localparam logic [CHAR_W-1:0]   CHAR_SPACE  = 7'h20;

    typedef struct packed {
        logic [SYMBOL_W-1:0] symbol;
        logic                end_of_text;
    } msd_item_t;

    typedef struct packed {
        logic              valid;
        logic [CHAR_W-1:0] decoded_char;
        logic              text_done;
    } msd_result_t;

    // dot=0 dash=1, first element in the most significant used bit
    function automatic logic [CHAR_W-1:0] morse_lookup(
        input logic [LOOKUP_LEN_W-1:0] len,
        input logic [LOOKUP_PAT_W-1:0] pat
    );
        logic [7:0] ch;
        unique case ({len, pat})
            {4'd2,  16'b01}:         ch = "A";
            {4'd4,  16'b1000}:       ch = "B";
            {4'd4,  16'b1010}:       ch = "C";
            {4'd3,  16'b100}:        ch = "D";
            {4'd1,  16'b0}:          ch = "E";
            {4'd4,  16'b0010}:       ch = "F";
            {4'd3,  16'b110}:        ch = "G";
            {4'd4,  16'b0000}:       ch = "H";
            {4'd2,  16'b00}:         ch = "I";
            {4'd4,  16'b0111}:       ch = "J";
            {4'd3,  16'b101}:        ch = "K";
            {4'd4,  16'b0100}:       ch = "L";
            {4'd2,  16'b11}:         ch = "M";
            {4'd2,  16'b10}:         ch = "N";
            {4'd3,  16'b111}:        ch = "O";
            {4'd4,  16'b0110}:       ch = "P";
            {4'd4,  16'b1101}:       ch = "Q";
            {4'd3,  16'b010}:        ch = "R";
            {4'd3,  16'b000}:        ch = "S";
            {4'd1,  16'b1}:          ch = "T";
            {4'd3,  16'b001}:        ch = "U";
            {4'd4,  16'b0001}:       ch = "V";
            {4'd3,  16'b011}:        ch = "W";
            {4'd4,  16'b1001}:       ch = "X";
            {4'd4,  16'b1011}:       ch = "Y";
            {4'd4,  16'b1100}:       ch = "Z";
            {4'd5,  16'b11111}:      ch = "0";
            {4'd5,  16'b01111}:      ch = "1";
            {4'd5,  16'b00111}:      ch = "2";
            {4'd5,  16'b00011}:      ch = "3";
            {4'd5,  16'b00001}:      ch = "4";
            {4'd5,  16'b00000}:      ch = "5";
            {4'd5,  16'b10000}:      ch = "6";
            {4'd5,  16'b11000}:      ch = "7";
            {4'd5,  16'b11100}:      ch = "8";
            {4'd5,  16'b11110}:      ch = "9";
            {4'd5,  16'b01000}:      ch = "&";
            {4'd6,  16'b011110}:     ch = "'";
            {4'd6,  16'b011010}:     ch = "@";
            {4'd6,  16'b101101}:     ch = ")";
            {4'd5,  16'b10110}:      ch = "(";
            {4'd6,  16'b111000}:     ch = ":";
            {4'd6,  16'b110011}:     ch = ",";
            {4'd5,  16'b10001}:      ch = "=";
            {4'd6,  16'b101011}:     ch = "!";
            {4'd6,  16'b010101}:     ch = ".";
            {4'd6,  16'b100001}:     ch = "-";
            {4'd10, 16'b1111100100}: ch = "%";
            {4'd5,  16'b01010}:      ch = "+";
            {4'd6,  16'b010010}:     ch = "\"";
            {4'd6,  16'b001100}:     ch = "?";
            {4'd5,  16'b10010}:      ch = "/";
            default:                 ch = " ";
        endcase
        return ch[CHAR_W-1:0];
    endfunction

endpackage

`default_nettype wire

>>> rtl/msd_if.sv
// ----------------------------------------------------------------------------
// msd_in_if / msd_out_if
// Valid/ready channels carrying Morse text bytes in and decoded characters out.
// ----------------------------------------------------------------------------
`default_nettype none

interface msd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] symbol;
    logic       end_of_text;

    modport source (output valid, output symbol, output end_of_text, input ready);
    modport sink   (input valid, input symbol, input end_of_text, output ready);
endinterface

interface msd_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] decoded_char;
    logic       text_done;

    modport source (output valid, output decoded_char, output text_done, input ready);
    modport sink   (input valid, input decoded_char, input text_done, output ready);
endinterface

`default_nettype wire

>>> rtl/msd_in_stage.sv
// ----------------------------------------------------------------------------
// msd_in_stage
// Input register: holds one accepted word until the decode stage takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module msd_in_stage
    import msd_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire msd_item_t in_item,
    input  wire logic      advance,
    output logic           item_valid,
    output msd_item_t      item
);

    logic      valid_reg;
    logic      valid_next;
    msd_item_t item_reg;

    assign in_ready   = !valid_reg || advance;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

endmodule

`default_nettype wire

>>> rtl/msd_decode.sv
// ----------------------------------------------------------------------------
// msd_decode
// Pending code register with append, completion and table lookup.
// ----------------------------------------------------------------------------
`default_nettype none

module msd_decode
    import msd_pkg::*;
#(
    parameter int MAX_CODE_LEN = 10
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      fire,
    input  wire msd_item_t item,
    output msd_result_t    result
);

    localparam int LEN_W = $clog2(MAX_CODE_LEN + 1);

    logic [MAX_CODE_LEN-1:0] pattern_reg;
    logic [MAX_CODE_LEN-1:0] pattern_next;
    logic [LEN_W-1:0]        length_reg;
    logic [LEN_W-1:0]        length_next;
    logic                    bad_reg;
    logic                    bad_next;

    logic                    is_space;
    logic                    is_dot;
    logic                    is_dash;
    logic                    full;
    logic [MAX_CODE_LEN-1:0] app_pattern;
    logic [LEN_W-1:0]        app_length;
    logic                    app_bad;
    logic [MAX_CODE_LEN-1:0] src_pattern;
    logic [LEN_W-1:0]        src_length;
    logic                    src_bad;
    logic [CHAR_W-1:0]       table_char;

    assign is_space = (item.symbol == ASCII_SPACE);
    assign is_dot   = (item.symbol == ASCII_DOT);
    assign is_dash  = (item.symbol == ASCII_DASH);
    assign full     = (length_reg == LEN_W'(MAX_CODE_LEN));

    // appended code; a full code keeps its elements and turns bad
    assign app_pattern = full ? pattern_reg : {pattern_reg[MAX_CODE_LEN-2:0], is_dash};
    assign app_length  = full ? length_reg : length_reg + LEN_W'(1);
    assign app_bad     = bad_reg || full || !(is_dot || is_dash);

    // a space completes the held code, end of text completes the appended one
    assign src_pattern = is_space ? pattern_reg : app_pattern;
    assign src_length  = is_space ? length_reg : app_length;
    assign src_bad     = is_space ? bad_reg : app_bad;

    assign table_char = morse_lookup(LOOKUP_LEN_W'(src_length), LOOKUP_PAT_W'(src_pattern));

    always_comb
    begin
        result.decoded_char = src_bad ? CHAR_SPACE : table_char;
        result.text_done    = item.end_of_text;
        result.valid        = 1'b0;
        pattern_next        = pattern_reg;
        length_next         = length_reg;
        bad_next            = bad_reg;
        if (is_space)
        begin
            result.valid = (length_reg != '0);
            pattern_next = '0;
            length_next  = '0;
            bad_next     = 1'b0;
        end
        else if (item.end_of_text)
        begin
            result.valid = 1'b1;
            pattern_next = '0;
            length_next  = '0;
            bad_next     = 1'b0;
        end
        else
        begin
            pattern_next = app_pattern;
            length_next  = app_length;
            bad_next     = app_bad;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg <= '0;
            length_reg  <= '0;
            bad_reg     <= 1'b0;
        end
        else if (fire)
        begin
            pattern_reg <= pattern_next;
            length_reg  <= length_next;
            bad_reg     <= bad_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/morse_stream_decoder_unit.sv
// ----------------------------------------------------------------------------
// morse_stream_decoder_unit
// Decodes a stream of Morse text bytes into ASCII characters.
//
// in_ch takes one byte of Morse text a word: '.', '-', a space between codes
// or any other byte, which spoils the pending code. end_of_text on a word
// flushes the pending code after that byte. out_ch gives one decoded
// character a word for every completed nonempty code; unknown, spoiled or
// overlong codes come out as a space, and text_done marks the character
// produced by an end-of-text word.
// An accepted word is held in the input register until the decode stage
// takes it; the decode stage then updates the code register and loads the
// result register. One word is accepted every cycle while out_ch does not
// stall; throughput is set by the single decode stage.
// Reset clears the pending code and both registers. While out_ch stalls
// with a character waiting, one more word is still taken into the input
// register; after that in_ch.ready follows out_ch.ready.
// ----------------------------------------------------------------------------
`default_nettype none

module morse_stream_decoder_unit
    import msd_pkg::*;
#(
    parameter int MAX_CODE_LEN = 10
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    msd_in_if.sink     in_ch,
    msd_out_if.source  out_ch
);

    msd_item_t         in_item;
    msd_item_t         item;
    logic              item_valid;
    logic              advance;
    logic              fire;
    msd_result_t       result;

    logic              out_valid_reg;
    logic              out_valid_next;
    logic [CHAR_W-1:0] out_char_reg;
    logic              out_done_reg;

    assign in_item.symbol      = in_ch.symbol;
    assign in_item.end_of_text = in_ch.end_of_text;

    assign advance = !out_valid_reg || out_ch.ready;
    assign fire    = item_valid && advance;

    msd_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_ch.valid),
        .in_ready   (in_ch.ready),
        .in_item    (in_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    msd_decode #(
        .MAX_CODE_LEN (MAX_CODE_LEN)
    ) u_decode (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (item),
        .result (result)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = fire && result.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && result.valid)
        begin
            out_char_reg <= result.decoded_char;
            out_done_reg <= result.text_done;
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.decoded_char = out_char_reg;
    assign out_ch.text_done    = out_done_reg;

    // an element without end of text never completes a code
    a_no_result_on_element: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && item.symbol != ASCII_SPACE && !item.end_of_text) |-> !result.valid)
        else $error("result produced by a plain element");

    // an element with end of text always flushes a nonempty code
    a_flush_on_eot_element: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && item.symbol != ASCII_SPACE && item.end_of_text) |-> result.valid)
        else $error("end of text element did not flush the code");

    // a completed code reaches the output register in the next cycle
    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && result.valid) |=> (out_ch.valid && out_ch.text_done == $past(result.text_done)))
        else $error("completed code not loaded into the result register");

endmodule

`default_nettype wire

>>> sim/morse_stream_decoder_unit_test.sv
// ----------------------------------------------------------------------------
// morse_stream_decoder_unit_test
// Self-checking testbench for the Morse stream decoder. Bytes of Morse text
// go in through in_ch, and a model of the code register predicts every
// decoded character. Each character on out_ch is compared with the oldest
// prediction. Both channels idle at random, except in one stretch.
// ----------------------------------------------------------------------------
`default_nettype none

module morse_stream_decoder_unit_test;

    timeunit 1ns;
    timeprecision 1ps;

    import msd_pkg::*;

    localparam int                  MAX_LEN     = 10;
    localparam int                  CYCLE_LIMIT = 400000;
    localparam int                  TABLE_LEN   = 52;
    localparam logic [SYMBOL_W-1:0] ASCII_SLASH = 8'h2F;

    typedef struct packed {
        logic [CHAR_W-1:0] decoded_char;
        logic              text_done;
    } decoded_char_t;

    string morse_codes [TABLE_LEN] = '{
        ".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..", ".---",
        "-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.", "...", "-",
        "..-", "...-", ".--", "-..-", "-.--", "--..",
        "-----", ".----", "..---", "...--", "....-", ".....", "-....", "--...",
        "---..", "----.",
        ".-...", ".----.", ".--.-.", "-.--.-", "-.--.", "---...", "--..--",
        "-...-", "-.-.--", ".-.-.-", "-....-", "-----..-..", ".-.-.", ".-..-.",
        "..--..", "-..-."
    };

    byte unsigned morse_chars [TABLE_LEN] = '{
        "A", "B", "C", "D", "E", "F", "G", "H", "I", "J",
        "K", "L", "M", "N", "O", "P", "Q", "R", "S", "T",
        "U", "V", "W", "X", "Y", "Z",
        "0", "1", "2", "3", "4", "5", "6", "7", "8", "9",
        "&", "'", "@", ")", "(", ":", ",", "=", "!", ".", "-", "%", "+", "\"",
        "?", "/"
    };

    logic clk;
    logic rst_n;

    msd_in_if  in_ch ();
    msd_out_if out_ch ();

    morse_stream_decoder_unit #(
        .MAX_CODE_LEN (MAX_LEN)
    ) i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // model of the pending code
    logic [MAX_LEN-1:0] code_pat;
    logic [3:0]         code_len;
    logic               code_bad;

    decoded_char_t pending_chars[$];
    int            fail_count  = 0;
    int            words_sent  = 0;
    int            cycle_count = 0;
    bit            idle_on     = 1'b1;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic logic [CHAR_W-1:0] char_for_code();
        logic [15:0] pat;
        int          n;
        string       s;
        if (code_bad)
            return CHAR_SPACE;
        for (int i = 0; i < TABLE_LEN; i++)
        begin
            s   = morse_codes[i];
            pat = '0;
            for (n = 0; n < s.len(); n++)
                pat = {pat[14:0], s[n] == "-"};
            if (n == code_len && pat == 16'(code_pat))
                return morse_chars[i][CHAR_W-1:0];
        end
        return CHAR_SPACE;
    endfunction

    task automatic flush_code(input logic done);
        decoded_char_t c;
        c.decoded_char = char_for_code();
        c.text_done    = done;
        pending_chars.push_back(c);
        code_pat = '0;
        code_len = '0;
        code_bad = 1'b0;
    endtask

    task automatic track_symbol(input logic [SYMBOL_W-1:0] sym, input logic eot);
        bit flushed;
        flushed = 1'b0;
        if (sym == ASCII_SPACE)
        begin
            if (code_len != 0)
            begin
                flush_code(eot);
                flushed = 1'b1;
            end
        end
        else
        begin
            if (sym != ASCII_DOT && sym != ASCII_DASH)
                code_bad = 1'b1;
            // past the last element the code only turns bad
            if (code_len >= MAX_LEN)
                code_bad = 1'b1;
            else
            begin
                code_pat = {code_pat[MAX_LEN-2:0], sym == ASCII_DASH};
                code_len = code_len + 1'b1;
            end
        end
        if (eot && !flushed && code_len != 0)
            flush_code(1'b1);
    endtask

    // result checker and receiver stalls
    always @(posedge clk)
    begin
        decoded_char_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_chars.size() == 0)
            begin
                $error("unexpected char %h text_done %b",
                       out_ch.decoded_char, out_ch.text_done);
                fail_count++;
            end
            else
            begin
                want = pending_chars.pop_front();
                if (out_ch.decoded_char !== want.decoded_char)
                begin
                    $error("decoded_char: expected %h, got %h",
                           want.decoded_char, out_ch.decoded_char);
                    fail_count++;
                end
                if (out_ch.text_done !== want.text_done)
                begin
                    $error("text_done: expected %b, got %b",
                           want.text_done, out_ch.text_done);
                    fail_count++;
                end
            end
        end
        out_ch.ready <= !(idle_on && $urandom_range(99) < 12);
    end

    task automatic send_symbol(input logic [SYMBOL_W-1:0] sym, input logic eot);
        int gap;
        gap = 0;
        if (idle_on && $urandom_range(99) < 5)
            gap = $urandom_range(1, 4);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.symbol      <= sym;
        in_ch.end_of_text <= eot;
        do
            @(posedge clk);
        while (!in_ch.ready);
        track_symbol(sym, eot);
        words_sent++;
    endtask

    task automatic send_code(input string s);
        for (int n = 0; n < s.len(); n++)
            send_symbol(s[n], 1'b0);
    endtask

    task automatic wait_for_drain();
        in_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_chars.size() != 0);
    endtask

    // one code with its separator or end of text, mostly well formed
    task automatic send_random_code();
        logic [SYMBOL_W-1:0] elems[$];
        string               s;
        int                  kind;
        int                  len;
        int                  tail;
        kind = $urandom_range(99);
        if (kind < 65)
        begin
            s = morse_codes[$urandom_range(TABLE_LEN-1)];
            for (int n = 0; n < s.len(); n++)
                elems.push_back(s[n] == "-" ? ASCII_DASH : ASCII_DOT);
        end
        else if (kind < 85)
        begin
            len = $urandom_range(1, MAX_LEN + 3);
            for (int n = 0; n < len; n++)
                elems.push_back($urandom_range(1) ? ASCII_DASH : ASCII_DOT);
        end
        else if (kind < 92)
            elems.push_back(ASCII_SLASH);
        else
        begin
            len = $urandom_range(1, 4);
            for (int n = 0; n < len; n++)
                elems.push_back(8'($urandom_range(255)));
        end
        tail = $urandom_range(99);
        for (int n = 0; n < elems.size(); n++)
            send_symbol(elems[n], tail >= 92 && n == elems.size() - 1);
        if (tail < 75)
            send_symbol(ASCII_SPACE, 1'b0);
        else if (tail < 85)
        begin
            send_symbol(ASCII_SPACE, 1'b0);
            send_symbol(ASCII_SPACE, $urandom_range(1));
        end
        else if (tail < 92)
            send_symbol(ASCII_SPACE, 1'b1);
    endtask

    task automatic test_directed();
        send_symbol(ASCII_SPACE, 1'b0);
        // lone slash between words
        send_symbol(ASCII_SLASH, 1'b0);
        send_symbol(ASCII_SPACE, 1'b0);
        // non-Morse bytes, flushed by end of text
        send_symbol(8'h00, 1'b0);
        send_symbol(8'hFF, 1'b1);
        // longest table code ended by a space with end of text
        send_code("-----..-..");
        send_symbol(ASCII_SPACE, 1'b1);
        // eleventh element overflows the code
        send_code("..-..--...");
        send_symbol(ASCII_DASH, 1'b1);
    endtask

    task automatic test_random_text(input int count);
        int target;
        target = words_sent + count;
        while (words_sent < target)
            send_random_code();
    endtask

    task automatic test_sender_pause();
        for (int r = 0; r < 6; r++)
        begin
            repeat ($urandom_range(1, 5)) send_random_code();
            wait_for_drain();
        end
    endtask

    task automatic test_no_idle(input int count);
        idle_on = 1'b0;
        test_random_text(count);
        idle_on = 1'b1;
    endtask

    initial
    begin
        rst_n             = 1'b0;
        in_ch.valid       = 1'b0;
        in_ch.symbol      = '0;
        in_ch.end_of_text = 1'b0;
        out_ch.ready      = 1'b0;
        code_pat          = '0;
        code_len          = '0;
        code_bad          = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_text(900);
        test_sender_pause();
        test_no_idle(400);
        test_random_text(600);

        wait_for_drain();
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire
